/* sv/bm25_pkg.sv */
// ----------------------------------------------------------------------------
// bm25_pkg
// Shared types, widths and constants for the BM25 score accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bm25_pkg;

  // field widths
  localparam int TF_W   = 16;
  localparam int DF_W   = 24;
  localparam int LEN_W  = 16;
  localparam int SCORE_W = 32;

  // default masking widths for the top level parameters
  localparam int TF_BITS_DEFAULT        = 16;
  localparam int DOC_COUNT_BITS_DEFAULT = 24;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam int K1_W       = 16;
  localparam int BW_W       = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DOCS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K1       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_WEIGHT = 8'd3;

  // digit-serial multiplier: 8-bit digits of a 32-bit multiplier
  localparam int MUL_A_W    = 72;
  localparam int MUL_B_W    = 32;
  localparam int MUL_DIG_W  = 8;
  localparam int MUL_DIGITS = MUL_B_W / MUL_DIG_W;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

  // bit-serial restoring divider
  localparam int DIV_W     = 49;
  localparam int DIVS_W    = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // log2 unit
  localparam int MANT_W    = 31;
  localparam int EXP_W     = 5;
  localparam int FRAC_W    = 16;
  localparam int LOG_W     = EXP_W + FRAC_W;
  localparam int STEP_W    = $clog2(FRAC_W);

  localparam logic [MUL_B_W-1:0] LN2_Q16 = 32'd45426;

  typedef struct packed {
    logic [TF_W-1:0]  term_freq;
    logic [DF_W-1:0]  doc_freq;
    logic [LEN_W-1:0] doc_length;
    logic             last_term;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               saturated;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOG_LOAD,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_LOG_SQ_W,
    ST_LOG_END,
    ST_IDF,
    ST_IDF_W,
    ST_RATIO,
    ST_RATIO_W,
    ST_NORM,
    ST_NORM_W,
    ST_DEN,
    ST_DEN_W,
    ST_NUM,
    ST_NUM_W,
    ST_WDIV,
    ST_WDIV_W,
    ST_TERM,
    ST_TERM_W,
    ST_ACC
  } bm25_state_t;

endpackage

`default_nettype wire

/* sv/bm25_dmul.sv */
// ----------------------------------------------------------------------------
// bm25_dmul
// Digit-serial multiplier: one 8-bit digit of the multiplier per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bm25_dmul import bm25_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [MUL_A_W-1:0]      prod
);

  logic [MUL_A_W-1:0]   a_sh;
  logic [MUL_B_W-1:0]   b_sh;
  logic [MUL_A_W-1:0]   acc;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-and-accumulate, product taken modulo the accumulator width
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= a;
      b_sh <= b;
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc + MUL_A_W'(a_sh * b_sh[MUL_DIG_W-1:0]);
      a_sh <= a_sh << MUL_DIG_W;
      b_sh <= b_sh >> MUL_DIG_W;
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

/* sv/bm25_sdiv.sv */
// ----------------------------------------------------------------------------
// bm25_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module bm25_sdiv import bm25_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       quot
);

  logic [DIV_W-1:0]     dvd;
  logic [DIVS_W-1:0]    dvs;
  logic [DIVS_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_W-1:0]     trial;
  logic                 ge;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem, dvd[DIV_W-1]};
  assign ge    = (trial >= DIV_W'(dvs));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? DIVS_W'(trial - DIV_W'(dvs)) : trial[DIVS_W-1:0];
      quot <= {quot[DIV_W-2:0], ge};
      dvd  <= dvd << 1;
    end
  end

endmodule

`default_nettype wire

/* sv/bm25_score_accumulator_core.sv */
// ----------------------------------------------------------------------------
// bm25_score_accumulator_core
// Okapi BM25 term scoring with a saturating per-document running sum.
// ----------------------------------------------------------------------------
// One query term is taken at a time, and the next term is taken only after
// its score has been accumulated. The time is spent on two log2
// evaluations by 16 squaring steps each (on the shared 8-bit digit
// multiplier, plus normalizing shifts of 2N+2 and 2df+1, 11 to 59 shifts
// in all), two passes of the bit-serial divider for the length ratio and
// the term weight, and five more digit-serial multiplies.
// The input stalls while a term is in flight. A finished score sits in the
// output register, so the next term is accepted while it waits; only a
// second last-term result stalls until the first has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module bm25_score_accumulator_core import bm25_pkg::*; #(
  parameter int TF_BITS        = TF_BITS_DEFAULT,
  parameter int DOC_COUNT_BITS = DOC_COUNT_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [TF_W-1:0] TF_MASK = TF_W'((64'd1 << TF_BITS) - 64'd1);
  localparam logic [DF_W-1:0] DC_MASK = DF_W'((64'd1 << DOC_COUNT_BITS) - 64'd1);

  bm25_state_t state, state_next;

  // configuration
  logic [DF_W-1:0] num_docs;
  logic [DF_W-1:0] avg_doc_length;
  logic [K1_W-1:0] k1;
  logic [BW_W-1:0] b_weight;

  // accumulator
  logic [SCORE_W-1:0] running_sum;
  logic               overflow_seen;

  // per-term working registers
  logic [TF_W-1:0]   tf;
  logic [DF_W-1:0]   df;
  logic [LEN_W-1:0]  len;
  logic              last;
  logic              log_sel;
  logic [MANT_W-1:0] mant;
  logic [EXP_W-1:0]  expo;
  logic [FRAC_W-1:0] frac;
  logic [STEP_W-1:0] step;
  logic [LOG_W-1:0]  la;
  logic [LOG_W-1:0]  idf;
  logic [39:0]       ratio;
  logic [41:0]       norm;
  logic [42:0]       den;
  logic [32:0]       num;
  logic [DIV_W-1:0]  weight;
  logic [53:0]       term;

  // shared units
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a, mul_prod;
  logic [MUL_B_W-1:0] mul_b;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dvd, div_quot;
  logic [DIVS_W-1:0]  div_dvs;

  // derived values
  logic [DF_W-1:0]    n_eff;
  logic [DF_W-1:0]    df_in;
  logic [DF_W-1:0]    avg_eff;
  logic [BW_W-1:0]    b_eff;
  logic [25:0]        log_arg;
  logic [31:0]        sq;
  logic [LOG_W-1:0]   lc;
  logic [LOG_W-1:0]   diff;
  logic [58:0]        norm_sum;
  logic [54:0]        sum_full;
  logic               sum_sat;
  logic [SCORE_W-1:0] sum_clip;
  logic               ovf_new;
  logic               finish;

  assign n_eff   = num_docs & DC_MASK;
  assign df_in   = in_item.doc_freq & DC_MASK;
  assign avg_eff = (avg_doc_length == '0) ? DF_W'(1) : avg_doc_length;
  assign b_eff   = (b_weight > BW_W'(17'h10000)) ? BW_W'(17'h10000) : b_weight;
  assign log_arg = log_sel ? 26'({df, 1'b1}) : (26'({n_eff, 1'b0}) + 26'd2);
  assign sq      = mul_prod[61:30];
  assign lc      = {expo, frac};
  assign diff    = (la > lc) ? (la - lc) : '0;
  assign norm_sum = 59'({(BW_W'(17'h10000) - b_eff), 16'h0000}) + 59'(mul_prod[55:0]);
  assign sum_full = 55'(running_sum) + 55'(term);
  assign sum_sat  = |sum_full[54:32];
  assign sum_clip = sum_sat ? '1 : sum_full[31:0];
  assign ovf_new  = overflow_seen | sum_sat;
  assign finish   = (state == ST_ACC) && (state_next == ST_IDLE);

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  bm25_dmul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  bm25_sdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit launches
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOG_LOAD;
      end
      ST_LOG_LOAD: state_next = ST_LOG_NORM;
      ST_LOG_NORM: begin
        if (mant[MANT_W-1]) state_next = ST_LOG_SQ;
      end
      ST_LOG_SQ: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(mant);
        mul_b      = MUL_B_W'(mant);
        state_next = ST_LOG_SQ_W;
      end
      ST_LOG_SQ_W: begin
        if (mul_done) begin
          state_next = (step == STEP_W'(FRAC_W - 1)) ? ST_LOG_END : ST_LOG_SQ;
        end
      end
      ST_LOG_END: state_next = log_sel ? ST_IDF : ST_LOG_LOAD;
      ST_IDF: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(diff);
        mul_b      = LN2_Q16;
        state_next = ST_IDF_W;
      end
      ST_IDF_W: begin
        if (mul_done) state_next = ST_RATIO;
      end
      ST_RATIO: begin
        div_start  = 1'b1;
        div_dvd    = DIV_W'({len, 24'h000000});
        div_dvs    = DIVS_W'(avg_eff);
        state_next = ST_RATIO_W;
      end
      ST_RATIO_W: begin
        if (div_done) state_next = ST_NORM;
      end
      ST_NORM: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(ratio);
        mul_b      = MUL_B_W'(b_eff);
        state_next = ST_NORM_W;
      end
      ST_NORM_W: begin
        if (mul_done) state_next = ST_DEN;
      end
      ST_DEN: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(norm);
        mul_b      = MUL_B_W'(k1);
        state_next = ST_DEN_W;
      end
      ST_DEN_W: begin
        if (mul_done) state_next = ST_NUM;
      end
      ST_NUM: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(k1) + MUL_A_W'(4096);
        mul_b      = MUL_B_W'(tf);
        state_next = ST_NUM_W;
      end
      ST_NUM_W: begin
        if (mul_done) state_next = ST_WDIV;
      end
      ST_WDIV: begin
        div_start  = 1'b1;
        div_dvd    = {num, 16'h0000};
        div_dvs    = DIVS_W'(den);
        state_next = ST_WDIV_W;
      end
      ST_WDIV_W: begin
        if (div_done) state_next = ST_TERM;
      end
      ST_TERM: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(weight);
        mul_b      = MUL_B_W'(idf);
        state_next = ST_TERM_W;
      end
      ST_TERM_W: begin
        if (mul_done) state_next = ST_ACC;
      end
      ST_ACC: begin
        // a second result waits until the first one is transferred
        if (!(last && out_valid && out_stall)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // per-term datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          tf      <= in_item.term_freq & TF_MASK;
          df      <= (df_in > n_eff) ? n_eff : df_in;
          len     <= in_item.doc_length;
          last    <= in_item.last_term;
          log_sel <= 1'b0;
        end
      end
      ST_LOG_LOAD: begin
        mant <= MANT_W'(log_arg);
        expo <= EXP_W'(MANT_W - 1);
        frac <= '0;
        step <= '0;
      end
      ST_LOG_NORM: begin
        if (!mant[MANT_W-1]) begin
          mant <= mant << 1;
          expo <= expo - 1'b1;
        end
      end
      ST_LOG_SQ_W: begin
        // square, renormalize into [1,2) and emit one fraction bit
        if (mul_done) begin
          if (sq[31]) begin
            mant <= sq[31:1];
            frac <= {frac[FRAC_W-2:0], 1'b1};
          end else begin
            mant <= sq[30:0];
            frac <= {frac[FRAC_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
        end
      end
      ST_LOG_END: begin
        if (!log_sel) begin
          la      <= {expo, frac};
          log_sel <= 1'b1;
        end
      end
      ST_IDF_W: begin
        if (mul_done) idf <= mul_prod[36:16];
      end
      ST_RATIO_W: begin
        if (div_done) ratio <= div_quot[39:0];
      end
      ST_NORM_W: begin
        if (mul_done) norm <= norm_sum[57:16];
      end
      ST_DEN_W: begin
        if (mul_done) den <= 43'({tf, 12'h000}) + 43'(mul_prod[57:16]);
      end
      ST_NUM_W: begin
        if (mul_done) num <= mul_prod[32:0];
      end
      ST_WDIV_W: begin
        // zero denominator gives zero weight
        if (div_done) weight <= (den == '0) ? '0 : div_quot;
      end
      ST_TERM_W: begin
        if (mul_done) term <= mul_prod[69:16];
      end
      default: ;
    endcase
  end

  // configuration, accumulator and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      num_docs       <= DF_W'(1);
      avg_doc_length <= DF_W'(256);
      k1             <= K1_W'(4915);
      b_weight       <= BW_W'(49152);
      running_sum    <= '0;
      overflow_seen  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_DOCS: num_docs       <= cfg_data;
          CFG_AVG_LEN:  avg_doc_length <= cfg_data;
          CFG_K1:       k1             <= cfg_data[K1_W-1:0];
          CFG_B_WEIGHT: b_weight       <= cfg_data[BW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (finish) begin
        if (last) begin
          out_valid     <= 1'b1;
          running_sum   <= '0;
          overflow_seen <= 1'b0;
        end else begin
          running_sum   <= sum_clip;
          overflow_seen <= ovf_new;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish && last) begin
      out_item.score     <= sum_clip;
      out_item.saturated <= ovf_new;
    end
  end

  // squaring always starts from a normalized mantissa
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOG_SQ) |-> mant[MANT_W-1])
    else $error("log mantissa not normalized at squaring step");

  // divider only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_RATIO_W || state == ST_WDIV_W))
    else $error("divider done outside a divide wait state");

  // multiplier only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_LOG_SQ_W || state == ST_IDF_W || state == ST_NORM_W ||
                  state == ST_DEN_W || state == ST_NUM_W || state == ST_TERM_W))
    else $error("multiplier done outside a multiply wait state");

  // a result only appears at the end of a last term
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_ACC && $past(last)))
    else $error("result raised outside the accumulate step of a last term");

endmodule

`default_nettype wire
